### hw/rtl/duration_percentile_statistics_unit_macros.svh
// Assertion macros used by the duration percentile statistics top level.
`ifndef DURATION_PERCENTILE_STATISTICS_UNIT_MACROS_SVH
`define DURATION_PERCENTILE_STATISTICS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, idle while reset is asserted.
`define DPS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, idle while reset is asserted.
`define DPS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DPS_ASSERT_IMPL(name, ante, cons, msg)
`define DPS_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

### hw/rtl/dps_pkg.sv
// Package with constants, codes and types of the duration percentile statistics unit.
package dps_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int DUR_W       = 64;
    localparam int VAL_W       = 63;
    localparam int BIT_W       = $clog2(VAL_W);
    localparam int NUM_PCT     = 3;
    localparam int PCT_LIST [NUM_PCT] = '{50, 95, 99};
    localparam int RANK_X_W    = $clog2(99 * MAX_SAMPLES + 100);
    // Division by 100 as a multiply by a reciprocal: floor(x * RANK_MUL / 2^RANK_SHIFT).
    localparam int RANK_SHIFT  = 32;
    localparam longint RANK_MUL = 42949673;
    localparam int RANK_MUL_W  = 26;
    localparam int RANK_PROD_W = RANK_X_W + RANK_MUL_W;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef logic [NUM_PCT-1:0][CNT_W-1:0] rank_vec_t;
    typedef logic [NUM_PCT-1:0][VAL_W-1:0] pick_vec_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_RANK,
        TOP_SELECT
    } top_state_t;

    typedef enum logic [1:0] {
        SEL_IDLE,
        SEL_SWEEP,
        SEL_DRAIN,
        SEL_DECIDE
    } sel_state_t;

endpackage

### hw/rtl/duration_percentile_statistics_unit.sv
// Top level of the duration percentile statistics unit.
//
//   Channel  Handshake         Word
//   input    start / busy      action, duration
//   output   result_valid      status, sample_count, smallest, largest, average,
//                              median_value, pct95_value, pct99_value
//
// An add word is checked and written to the sample
// store, and busy stays low, so adds can come in every cycle.
// A finish word on an empty set or after an error gives its result in the next cycle.
// Otherwise a finish word runs a selection over the n stored samples: the selector
// sweeps the store once per bit of the 63-bit value, reading one entry per cycle
// through the single read port, while the mean divider runs beside it.
// Reset is asynchronous and clears the set; the store itself is never cleared.
// The receiver cannot stall, so result_valid is high for one cycle only.
`include "duration_percentile_statistics_unit_macros.svh"
module duration_percentile_statistics_unit import dps_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             action,
    input  logic [DUR_W-1:0] duration,
    output logic             result_valid,
    output logic [1:0]       status,
    output logic [CNT_W-1:0] sample_count,
    output logic [VAL_W-1:0] smallest,
    output logic [VAL_W-1:0] largest,
    output logic [VAL_W-1:0] average,
    output logic [VAL_W-1:0] median_value,
    output logic [VAL_W-1:0] pct95_value,
    output logic [VAL_W-1:0] pct99_value
);

    top_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [VAL_W-1:0] sum_reg, sum_next;
    logic [1:0]       err_reg, err_next;
    logic [VAL_W-1:0] min_reg, min_next;
    logic [VAL_W-1:0] max_reg, max_next;
    logic [NUM_PCT-1:0][RANK_X_W-1:0] rx_reg, rx_next;
    rank_vec_t        rank_reg, rank_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic [VAL_W-1:0] out_min_reg, out_min_next;
    logic [VAL_W-1:0] out_max_reg, out_max_next;
    logic [VAL_W-1:0] out_avg_reg, out_avg_next;
    pick_vec_t        out_pick_reg, out_pick_next;

    logic             accept;
    logic             mem_we;
    logic [DUR_W-1:0] sum_wide;
    logic [RANK_PROD_W-1:0] rank_prod;
    logic             sel_start;
    logic [ADDR_W-1:0] rd_addr;
    logic [VAL_W-1:0] rd_data;
    logic             sel_done;
    pick_vec_t        sel_pick;
    logic [VAL_W-1:0] quotient;

    // Sample store: one write per add, one read per cycle for the selector.
    dps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (duration[VAL_W-1:0]),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    dps_select u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sel_start),
        .count   (count_reg),
        .rank    (rank_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (sel_done),
        .pick    (sel_pick)
    );

    dps_divide u_divide (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sel_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TOP_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg        <= min_next;
        max_reg        <= max_next;
        rx_reg         <= rx_next;
        rank_reg       <= rank_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_min_reg    <= out_min_next;
        out_max_reg    <= out_max_next;
        out_avg_reg    <= out_avg_next;
        out_pick_reg   <= out_pick_next;
    end

    assign busy      = (state_reg != TOP_IDLE);
    assign accept    = start && !busy;
    assign sel_start = (state_reg == TOP_RANK);
    assign sum_wide  = {1'b0, sum_reg} + {1'b0, duration[VAL_W-1:0]};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        err_next        = err_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        rx_next         = rx_reg;
        rank_next       = rank_reg;
        out_valid_next  = 1'b0;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_min_next    = out_min_reg;
        out_max_next    = out_max_reg;
        out_avg_next    = out_avg_reg;
        out_pick_next   = out_pick_reg;
        mem_we          = 1'b0;
        rank_prod       = '0;
        case (state_reg)
            TOP_IDLE:
            begin
                if (accept && action == ACT_ADD && err_reg == ST_OK)
                begin
                    // The first error sticks; the failing sample is dropped.
                    if (duration[DUR_W-1])
                    begin
                        err_next = ST_BAD;
                    end
                    else if (count_reg == CNT_W'(MAX_SAMPLES))
                    begin
                        err_next = ST_FULL;
                    end
                    else if (sum_wide[VAL_W])
                    begin
                        err_next = ST_BAD;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_wide[VAL_W-1:0];
                        if (count_reg == '0 || duration[VAL_W-1:0] < min_reg)
                        begin
                            min_next = duration[VAL_W-1:0];
                        end
                        if (count_reg == '0 || duration[VAL_W-1:0] > max_reg)
                        begin
                            max_next = duration[VAL_W-1:0];
                        end
                    end
                end
                else if (accept && action == ACT_FINISH)
                begin
                    if (err_reg != ST_OK || count_reg == '0)
                    begin
                        // Error or empty set: status alone, every value zero.
                        out_valid_next  = 1'b1;
                        out_status_next = err_reg;
                        out_count_next  = '0;
                        out_min_next    = '0;
                        out_max_next    = '0;
                        out_avg_next    = '0;
                        out_pick_next   = '0;
                        count_next      = '0;
                        sum_next        = '0;
                        err_next        = ST_OK;
                    end
                    else
                    begin
                        // p * n + 99, divided by 100 in the next cycle.
                        for (int k = 0; k < NUM_PCT; k++)
                        begin
                            rx_next[k] = RANK_X_W'(RANK_X_W'(PCT_LIST[k]) * RANK_X_W'(count_reg))
                                         + RANK_X_W'(99);
                        end
                        state_next = TOP_RANK;
                    end
                end
            end
            TOP_RANK:
            begin
                for (int k = 0; k < NUM_PCT; k++)
                begin
                    rank_prod    = RANK_PROD_W'(rx_reg[k]) * RANK_PROD_W'(RANK_MUL);
                    rank_next[k] = CNT_W'(rank_prod >> RANK_SHIFT);
                end
                state_next = TOP_SELECT;
            end
            TOP_SELECT:
            begin
                if (sel_done)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_count_next  = count_reg;
                    out_min_next    = min_reg;
                    out_max_next    = max_reg;
                    out_avg_next    = quotient;
                    out_pick_next   = sel_pick;
                    count_next      = '0;
                    sum_next        = '0;
                    err_next        = ST_OK;
                    state_next      = TOP_IDLE;
                end
            end
            default:
            begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign sample_count = out_count_reg;
    assign smallest     = out_min_reg;
    assign largest      = out_max_reg;
    assign average      = out_avg_reg;
    assign median_value = out_pick_reg[0];
    assign pct95_value  = out_pick_reg[1];
    assign pct99_value  = out_pick_reg[2];

    // An error result carries no sample count and no mean.
    `DPS_ASSERT_IMPL(a_err_zero, result_valid && status != ST_OK, sample_count == '0 && average == '0, "error result carries values")
    // A finish word either answers in the next cycle or starts the selection.
    `DPS_ASSERT_NEXT(a_finish_answers, accept && action == ACT_FINISH, result_valid || busy, "finish word lost")
    // Selection only ever runs over a non-empty, error-free set.
    `DPS_ASSERT_IMPL(a_select_set, state_reg == TOP_SELECT, count_reg != '0 && err_reg == ST_OK, "selection on empty or failed set")

endmodule

### hw/rtl/dps_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module dps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/dps_divide.sv
// Restoring divider that forms the truncated mean one quotient bit per cycle.
module dps_divide import dps_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic [VAL_W-1:0] quotient
);

    logic             active_reg, active_next;
    logic [BIT_W-1:0] step_reg, step_next;
    logic [VAL_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] den_reg, den_next;
    logic [CNT_W:0]   rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        rem_sh      = {rem_reg, quo_reg[VAL_W-1]};
        if (start)
        begin
            active_next = 1'b1;
            step_next   = BIT_W'(VAL_W - 1);
            quo_next    = dividend;
            rem_next    = '0;
            den_next    = divisor;
        end
        else if (active_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = CNT_W'(rem_sh - {1'b0, den_reg});
                quo_next = {quo_reg[VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[CNT_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], 1'b0};
            end
            if (step_reg == '0)
            begin
                active_next = 1'b0;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    assign quotient = quo_reg;

endmodule

### hw/rtl/dps_select.sv
// Radix selection of the percentile samples by repeated counting sweeps over the store.
module dps_select import dps_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CNT_W-1:0]  count,
    input  rank_vec_t         rank,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [VAL_W-1:0]  rd_data,
    output logic              done,
    output pick_vec_t         pick
);

    sel_state_t       state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    rank_vec_t        cnt_reg, cnt_next;
    pick_vec_t        prefix_reg, prefix_next;
    pick_vec_t        trial;
    logic             rdv_reg, rdv_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] addr_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEL_IDLE;
            rdv_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg   <= rdv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        addr_reg   <= addr_next;
        bit_reg    <= bit_next;
        cnt_reg    <= cnt_next;
        prefix_reg <= prefix_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        addr_next   = addr_reg;
        bit_next    = bit_reg;
        cnt_next    = cnt_reg;
        prefix_next = prefix_reg;
        rdv_next    = 1'b0;
        done_next   = 1'b0;
        addr_inc    = addr_reg + 1'b1;
        for (int k = 0; k < NUM_PCT; k++)
        begin
            trial[k] = prefix_reg[k] | (VAL_W'(1) << bit_reg);
            if (rdv_reg)
            begin
                cnt_next[k] = cnt_reg[k] + CNT_W'(rd_data < trial[k]);
            end
        end
        case (state_reg)
            SEL_IDLE:
            begin
                if (start)
                begin
                    n_next      = count;
                    addr_next   = '0;
                    bit_next    = BIT_W'(VAL_W - 1);
                    prefix_next = '0;
                    cnt_next    = '0;
                    state_next  = SEL_SWEEP;
                end
            end
            SEL_SWEEP:
            begin
                rdv_next  = 1'b1;
                addr_next = addr_inc;
                if (addr_inc == n_reg)
                begin
                    state_next = SEL_DRAIN;
                end
            end
            SEL_DRAIN:
            begin
                state_next = SEL_DECIDE;
            end
            SEL_DECIDE:
            begin
                // Fewer samples below the trial than the rank: the answer is at least the trial.
                for (int k = 0; k < NUM_PCT; k++)
                begin
                    if (cnt_reg[k] < rank[k])
                    begin
                        prefix_next[k] = trial[k];
                    end
                end
                cnt_next  = '0;
                addr_next = '0;
                if (bit_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = SEL_IDLE;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = SEL_SWEEP;
                end
            end
            default:
            begin
                state_next = SEL_IDLE;
            end
        endcase
    end

    assign rd_addr = addr_reg[ADDR_W-1:0];
    assign done    = done_reg;
    assign pick    = prefix_reg;

endmodule
